// ===== hdl/tccs_pkg.sv =====
// Package for the transmission clutch slip model.
// Holds gear codes, register indexes, pipeline types and the fixed-point helpers.
// No dependencies.
package tccs_pkg;

    localparam int RATIO_FRAC_BITS = 12;
    localparam int QUOT_BITS       = 16 + RATIO_FRAC_BITS;
    localparam int NUM_W           = 48;

    localparam logic [3:0] G_NEUTRAL = 4'd0;
    localparam logic [3:0] G_PARK    = 4'd1;
    localparam logic [3:0] G_FIRST   = 4'd2;
    localparam logic [3:0] G_SECOND  = 4'd3;
    localparam logic [3:0] G_THIRD   = 4'd4;
    localparam logic [3:0] G_FOURTH  = 4'd5;
    localparam logic [3:0] G_FIFTH   = 4'd6;
    localparam logic [3:0] G_REV1    = 4'd7;
    localparam logic [3:0] G_REV2    = 4'd8;

    localparam logic [1:0] CFG_RATIO_SECOND = 2'd0;
    localparam logic [1:0] CFG_RATIO_THIRD  = 2'd1;
    localparam logic [1:0] CFG_RATIO_FOURTH = 2'd2;

    localparam logic signed [15:0] RATIO_SECOND_RST = 16'sd9871;
    localparam logic signed [15:0] RATIO_THIRD_RST  = 16'sd6103;
    localparam logic signed [15:0] RATIO_FOURTH_RST = 16'sd4096;

    typedef enum logic [1:0] {
        QD_NONE,
        QD_B2,
        QD_K3
    } t_qdst;

    typedef struct packed {
        logic signed [15:0] k1;
        logic signed [15:0] k2;
        logic signed [15:0] k3;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] b3;
    } t_fields;

    typedef struct packed {
        t_qdst q_dst;
        logic  q_long;
        logic  q_inv;
        logic  k2_sp;
        logic  b3_pr;
        logic  k3_fix;
    } t_ctl;

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // divide by 2^F toward zero, then saturate
    function automatic logic signed [15:0] trunc_sat(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = v >>> RATIO_FRAC_BITS;
        if (v[33] && (v[RATIO_FRAC_BITS-1:0] != '0)) begin
            t = t + 34'sd1;
        end
        return sat16(t);
    endfunction

endpackage

// ===== hdl/transmission_clutch_slip_model.sv =====
// Clutch slip model: a request passes stages 0 to 3, the divider stages and the output
// register to o_valid; one request per cycle, busy is always low.
// Rate is set by a fully pipelined restoring divider, one quotient bit per stage.
// Synchronous active-low reset clears the valid bits and loads the reset ratios.
// Results are strobed on o_valid for one cycle; the receiver cannot stall.
// Depends on tccs_pkg.
module transmission_clutch_slip_model (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [14:0] i_n2_speed,
    input  logic        [14:0] i_n3_speed,
    input  logic        [14:0] i_turbine_speed,
    input  logic        [14:0] i_output_speed,
    input  logic        [3:0]  i_actual_gear,
    input  logic        [3:0]  i_target_gear,
    input  logic        [3:0]  i_last_motion_gear,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_slip_k1,
    output logic signed [15:0] o_slip_k2,
    output logic signed [15:0] o_slip_k3,
    output logic signed [15:0] o_slip_b1,
    output logic signed [15:0] o_slip_b2,
    output logic signed [15:0] o_slip_b3
);

    localparam int F  = tccs_pkg::RATIO_FRAC_BITS;
    localparam int QB = tccs_pkg::QUOT_BITS;
    localparam int NW = tccs_pkg::NUM_W;

    logic signed [15:0] r_ratio2, r_ratio3, r_ratio4;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio2 <= tccs_pkg::RATIO_SECOND_RST;
            r_ratio3 <= tccs_pkg::RATIO_THIRD_RST;
            r_ratio4 <= tccs_pkg::RATIO_FOURTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tccs_pkg::CFG_RATIO_SECOND: r_ratio2 <= i_cfg_data;
                tccs_pkg::CFG_RATIO_THIRD:  r_ratio3 <= i_cfg_data;
                tccs_pkg::CFG_RATIO_FOURTH: r_ratio4 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- decode ----------------
    tccs_pkg::t_fields  n_f;
    tccs_pkg::t_ctl     n_c;
    logic               n_pair23, n_qin_tu, n_sp_tu;
    logic        [3:0]  g, lo, hi;
    logic signed [15:0] n2s, n3s, tus, dk1;

    always_comb begin
        n2s = $signed({1'b0, i_n2_speed});
        n3s = $signed({1'b0, i_n3_speed});
        tus = $signed({1'b0, i_turbine_speed});
        dk1 = n2s - n3s;
        n_f = '0;
        n_c = '0;
        n_c.q_dst = tccs_pkg::QD_NONE;
        n_pair23 = 1'b0;
        n_qin_tu = 1'b0;
        n_sp_tu  = 1'b0;
        g  = i_last_motion_gear;
        lo = (i_actual_gear < i_target_gear) ? i_actual_gear : i_target_gear;
        hi = (i_actual_gear < i_target_gear) ? i_target_gear : i_actual_gear;
        if (i_actual_gear == tccs_pkg::G_NEUTRAL || i_target_gear == tccs_pkg::G_NEUTRAL ||
            i_actual_gear == tccs_pkg::G_PARK || i_target_gear == tccs_pkg::G_PARK) begin
            if ((i_actual_gear == tccs_pkg::G_NEUTRAL && i_target_gear != tccs_pkg::G_NEUTRAL) ||
                (i_actual_gear == tccs_pkg::G_PARK && i_target_gear != tccs_pkg::G_PARK)) begin
                g = i_target_gear;
            end
            case (g)
                tccs_pkg::G_FIRST: begin
                    n_f.k1 = dk1; n_f.b2 = tus;
                end
                tccs_pkg::G_SECOND, tccs_pkg::G_THIRD, tccs_pkg::G_FOURTH: begin
                    n_f.b1 = n3s; n_f.b2 = n3s;
                end
                tccs_pkg::G_FIFTH: begin
                    n_f.b1 = tus; n_c.q_dst = tccs_pkg::QD_B2; n_c.q_long = 1'b1;
                    n_qin_tu = 1'b1;
                end
                tccs_pkg::G_REV1: begin
                    n_f.k1 = dk1; n_c.q_dst = tccs_pkg::QD_B2; n_c.q_long = 1'b1;
                    n_c.q_inv = 1'b1; n_qin_tu = 1'b1;
                end
                tccs_pkg::G_REV2: begin
                    n_f.b1 = tus; n_c.q_dst = tccs_pkg::QD_B2; n_c.q_long = 1'b1;
                    n_c.q_inv = 1'b1; n_qin_tu = 1'b1;
                end
                default: ;
            endcase
        end else if (i_output_speed != '0) begin
            if (i_target_gear == i_actual_gear) begin
                case (i_actual_gear)
                    tccs_pkg::G_FIRST: begin
                        n_f.k1 = dk1; n_c.k2_sp = 1'b1; n_sp_tu = 1'b1; n_c.b3_pr = 1'b1;
                    end
                    tccs_pkg::G_SECOND: begin
                        n_c.k2_sp = 1'b1; n_f.b1 = n3s; n_c.b3_pr = 1'b1;
                    end
                    tccs_pkg::G_THIRD: begin
                        n_c.q_dst = tccs_pkg::QD_K3; n_c.q_long = 1'b1; n_pair23 = 1'b1;
                        n_f.b1 = n3s; n_f.b3 = n3s;
                    end
                    tccs_pkg::G_FOURTH: begin
                        n_f.b1 = n3s; n_c.q_dst = tccs_pkg::QD_B2; n_f.b3 = n3s;
                    end
                    tccs_pkg::G_FIFTH: begin
                        n_c.q_dst = tccs_pkg::QD_B2; n_qin_tu = 1'b1; n_f.k1 = dk1;
                        n_f.b3 = tus;
                    end
                    tccs_pkg::G_REV1: begin
                        n_f.k1 = dk1; n_f.k2 = tus; n_c.q_dst = tccs_pkg::QD_B2;
                        n_c.q_long = 1'b1; n_c.q_inv = 1'b1; n_qin_tu = 1'b1;
                    end
                    tccs_pkg::G_REV2: begin
                        n_f.k2 = tus; n_f.b1 = tus; n_c.q_dst = tccs_pkg::QD_B2;
                        n_c.q_long = 1'b1; n_c.q_inv = 1'b1; n_qin_tu = 1'b1;
                    end
                    default: ;
                endcase
            end else if (lo == tccs_pkg::G_FIRST && hi == tccs_pkg::G_SECOND) begin
                n_f.k1 = dk1; n_c.k2_sp = 1'b1; n_sp_tu = 1'b1; n_f.b1 = n3s;
                n_c.b3_pr = 1'b1;
            end else if (lo == tccs_pkg::G_SECOND && hi == tccs_pkg::G_THIRD) begin
                n_c.k2_sp = 1'b1; n_c.q_dst = tccs_pkg::QD_K3; n_c.q_long = 1'b1;
                n_pair23 = 1'b1; n_f.b1 = n3s; n_c.b3_pr = 1'b1;
            end else if (lo == tccs_pkg::G_THIRD && hi == tccs_pkg::G_FOURTH) begin
                n_c.q_dst = tccs_pkg::QD_B2; n_c.k3_fix = 1'b1; n_f.k3 = n3s;
                n_f.b1 = n3s; n_f.b3 = n3s;
            end else if (lo == tccs_pkg::G_FOURTH && hi == tccs_pkg::G_FIFTH) begin
                n_f.k1 = dk1; n_f.b1 = n3s; n_c.q_dst = tccs_pkg::QD_B2; n_qin_tu = 1'b1;
                n_f.b3 = tus;
            end
        end
    end

    // ---------------- stage 0 ----------------
    logic                r0_v;
    tccs_pkg::t_fields   r0_f;
    tccs_pkg::t_ctl      r0_c;
    logic        [14:0]  r0_os, r0_qin, r0_spa;
    logic signed [15:0]  r0_rl, r0_rh, r0_r3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start;
        end
        r0_f   <= n_f;
        r0_c   <= n_c;
        r0_os  <= i_output_speed;
        r0_qin <= n_qin_tu ? i_turbine_speed : i_n3_speed;
        r0_spa <= n_sp_tu ? i_turbine_speed : i_n3_speed;
        r0_rl  <= n_pair23 ? r_ratio2 : r_ratio3;
        r0_rh  <= n_pair23 ? r_ratio3 : r_ratio4;
        r0_r3  <= r_ratio3;
    end

    // ---------------- stage 1: products ----------------
    logic                r1_v;
    tccs_pkg::t_fields   r1_f;
    tccs_pkg::t_ctl      r1_c;
    logic        [14:0]  r1_qin, r1_spa;
    logic signed [15:0]  r1_rl, r1_rh;
    logic signed [31:0]  r1_p3, r1_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        r1_f   <= r0_f;
        r1_c   <= r0_c;
        r1_qin <= r0_qin;
        r1_spa <= r0_spa;
        r1_rl  <= r0_rl;
        r1_rh  <= r0_rh;
        r1_p3  <= 32'(r0_r3) * 32'($signed({1'b0, r0_os}));
        r1_pl  <= 32'(r0_rl) * 32'($signed({1'b0, r0_os}));
    end

    // ---------------- stage 2: numerator, divisor, direct products ----------------
    logic                r2_v;
    tccs_pkg::t_fields   r2_f;
    tccs_pkg::t_ctl      r2_c;
    logic signed [15:0]  r2_rh;
    logic signed [33:0]  r2_x;
    logic signed [16:0]  r2_d;
    logic signed [33:0]  n_spv, n_inq;
    tccs_pkg::t_fields   n2_f;

    always_comb begin
        n_spv = (34'($signed({1'b0, r1_spa})) <<< F) - 34'(r1_p3);
        n_inq = 34'($signed({1'b0, r1_qin})) <<< F;
        n2_f  = r1_f;
        if (r1_c.k2_sp) begin
            n2_f.k2 = tccs_pkg::trunc_sat(n_spv);
        end
        if (r1_c.b3_pr) begin
            n2_f.b3 = tccs_pkg::trunc_sat(34'(r1_p3));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_f  <= n2_f;
        r2_c  <= r1_c;
        r2_rh <= r1_rh;
        r2_x  <= r1_c.q_inv ? (34'(r1_pl) + n_inq) : (34'(r1_pl) - n_inq);
        r2_d  <= 17'(r1_rl) - 17'(r1_rh);
    end

    // ---------------- stage 3: dividend magnitude ----------------
    logic                r3_v;
    tccs_pkg::t_fields   r3_f;
    tccs_pkg::t_ctl      r3_c;
    logic        [NW-1:0] r3_n;
    logic        [15:0]  r3_dm;
    logic                r3_neg, r3_dz;
    logic        [33:0]  n_ax;
    logic        [16:0]  n_arh, n_ad;

    always_comb begin
        n_ax  = r2_x[33] ? 34'(-r2_x) : 34'(r2_x);
        n_arh = r2_rh[15] ? 17'(-17'(r2_rh)) : 17'(r2_rh);
        n_ad  = r2_d[16] ? 17'(-r2_d) : 17'(r2_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_f  <= r2_f;
        r3_c  <= r2_c;
        r3_n  <= r2_c.q_long ? (NW'(n_arh[15:0]) * NW'(n_ax[31:0]))
                             : (NW'(n_ax) << F);
        r3_dm <= n_ad[15:0];
        r3_dz <= (r2_d == '0);
        r3_neg <= r2_c.q_long ? (r2_rh[15] ^ r2_x[33] ^ r2_d[16]) : (r2_x[33] ^ r2_d[16]);
    end

    // ---------------- divider: overflow check then one bit per stage ----------------
    logic                dv_v   [0:QB];
    tccs_pkg::t_fields   dv_f   [0:QB];
    tccs_pkg::t_ctl      dv_c   [0:QB];
    logic        [NW-1:0] dv_rem [0:QB];
    logic        [QB-1:0] dv_q   [0:QB];
    logic        [15:0]  dv_dm  [0:QB];
    logic                dv_ovf [0:QB];
    logic                dv_neg [0:QB];
    logic                dv_dz  [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else begin
            dv_v[0] <= r3_v;
        end
        dv_f[0]   <= r3_f;
        dv_c[0]   <= r3_c;
        dv_rem[0] <= r3_n;
        dv_q[0]   <= '0;
        dv_dm[0]  <= r3_dm;
        dv_ovf[0] <= (r3_n >= (NW'(r3_dm) << QB));
        dv_neg[0] <= r3_neg;
        dv_dz[0]  <= r3_dz;
    end

    genvar j;
    generate
        for (j = 1; j <= QB; j++) begin : g_div
            logic [NW-1:0] sh;
            logic          ge;
            assign sh = NW'(dv_dm[j-1]) << (QB - j);
            assign ge = (dv_rem[j-1] >= sh);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    dv_v[j] <= 1'b0;
                end else begin
                    dv_v[j] <= dv_v[j-1];
                end
                dv_f[j]   <= dv_f[j-1];
                dv_c[j]   <= dv_c[j-1];
                dv_rem[j] <= ge ? (dv_rem[j-1] - sh) : dv_rem[j-1];
                dv_q[j]   <= dv_q[j-1] | (ge ? (QB'(1) << (QB - j)) : '0);
                dv_dm[j]  <= dv_dm[j-1];
                dv_ovf[j] <= dv_ovf[j-1];
                dv_neg[j] <= dv_neg[j-1];
                dv_dz[j]  <= dv_dz[j-1];
            end
        end
    endgenerate

    // ---------------- output stage ----------------
    logic                r_ov;
    tccs_pkg::t_fields   r_of;
    tccs_pkg::t_fields   n_of;
    logic        [15:0]  n_qm;
    logic signed [15:0]  n_qs;

    always_comb begin
        n_qm = dv_q[QB][QB-1:F];
        if (dv_dz[QB]) begin
            n_qs = '0;
        end else if (dv_neg[QB]) begin
            n_qs = (dv_ovf[QB] || n_qm > 16'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, n_qm}));
        end else begin
            n_qs = (dv_ovf[QB] || n_qm > 16'd32767) ? 16'sh7fff : $signed(n_qm);
        end
        n_of = dv_f[QB];
        case (dv_c[QB].q_dst)
            tccs_pkg::QD_B2: n_of.b2 = n_qs;
            tccs_pkg::QD_K3: n_of.k3 = n_qs;
            default: ;
        endcase
        if (dv_c[QB].k3_fix) begin
            n_of.k3 = tccs_pkg::sat16(34'(dv_f[QB].k3) - 34'(n_qs));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= dv_v[QB];
        end
        r_of <= n_of;
    end

    assign o_valid   = r_ov;
    assign o_slip_k1 = r_of.k1;
    assign o_slip_k2 = r_of.k2;
    assign o_slip_k3 = r_of.k3;
    assign o_slip_b1 = r_of.b1;
    assign o_slip_b2 = r_of.b2;
    assign o_slip_b3 = r_of.b3;

endmodule

// ===== test/transmission_clutch_slip_model_chk.sv =====
// Checker for the clutch slip model: watches requests, config writes and results.
// Predicts the six slip speeds in order and compares them field by field.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
module transmission_clutch_slip_model_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic        [14:0] i_n2,
    input  logic        [14:0] i_n3,
    input  logic        [14:0] i_tu,
    input  logic        [14:0] i_os,
    input  logic        [3:0]  i_act,
    input  logic        [3:0]  i_tgt,
    input  logic        [3:0]  i_lmg,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data,
    input  logic               i_valid,
    input  tccs_pkg::t_fields  i_slip,
    output int                 o_errors,
    output int                 o_pending
);

    localparam longint ONE_Q = longint'(1) << tccs_pkg::RATIO_FRAC_BITS;

    logic signed [15:0] r2_q, r3_q, r4_q;
    tccs_pkg::t_fields  slip_q[$];

    function automatic longint clip(input longint v);
        longint r;
        r = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
        return r;
    endfunction

    function automatic longint minus_prod(input longint a, input longint r, input longint s);
        return clip((a * ONE_Q - r * s) / ONE_Q);
    endfunction

    function automatic longint scaled(input longint r, input longint s);
        return clip((r * s) / ONE_Q);
    endfunction

    function automatic longint ratio_quot(input longint os, input longint sp,
                                          input longint rl, input longint rh);
        longint d;
        d = rl - rh;
        if (d == 0) return 0;
        return clip((rl * os - sp * ONE_Q) / d);
    endfunction

    function automatic longint wide_quot(input longint os, input longint sp, input longint rl,
                                         input longint rh, input bit inv);
        longint d, x;
        d = rl - rh;
        if (d == 0) return 0;
        x = inv ? rl * os + sp * ONE_Q : rl * os - sp * ONE_Q;
        return clip((rh * x) / (d * ONE_Q));
    endfunction

    function automatic tccs_pkg::t_fields slip_speeds(input longint n2, input longint n3,
                                                      input longint tu, input longint os,
                                                      input logic [3:0] act,
                                                      input logic [3:0] tgt,
                                                      input logic [3:0] lmg,
                                                      input longint r2, input longint r3,
                                                      input longint r4);
        longint k1, k2, k3, b1, b2, b3, vb2;
        logic [3:0] g, lo, hi;
        tccs_pkg::t_fields f;
        k1 = 0; k2 = 0; k3 = 0; b1 = 0; b2 = 0; b3 = 0;
        if (act == tccs_pkg::G_NEUTRAL || tgt == tccs_pkg::G_NEUTRAL ||
            act == tccs_pkg::G_PARK || tgt == tccs_pkg::G_PARK) begin
            g = lmg;
            if ((act == tccs_pkg::G_NEUTRAL && tgt != tccs_pkg::G_NEUTRAL) ||
                (act == tccs_pkg::G_PARK && tgt != tccs_pkg::G_PARK))
                g = tgt;
            case (g)
                tccs_pkg::G_FIRST: begin k1 = n2 - n3; b2 = tu; end
                tccs_pkg::G_SECOND, tccs_pkg::G_THIRD, tccs_pkg::G_FOURTH: begin
                    b1 = n3; b2 = n3;
                end
                tccs_pkg::G_FIFTH: begin b1 = tu; b2 = wide_quot(os, tu, r3, r4, 0); end
                tccs_pkg::G_REV1: begin k1 = n2 - n3; b2 = wide_quot(os, tu, r3, r4, 1); end
                tccs_pkg::G_REV2: begin b1 = tu; b2 = wide_quot(os, tu, r3, r4, 1); end
                default: ;
            endcase
        end else if (os != 0) begin
            if (tgt == act) begin
                case (act)
                    tccs_pkg::G_FIRST: begin
                        k1 = n2 - n3; k2 = minus_prod(tu, r3, os); b3 = scaled(r3, os);
                    end
                    tccs_pkg::G_SECOND: begin
                        k2 = minus_prod(n3, r3, os); b1 = n3; b3 = scaled(r3, os);
                    end
                    tccs_pkg::G_THIRD: begin
                        k3 = wide_quot(os, n3, r2, r3, 0); b1 = n3; b3 = n3;
                    end
                    tccs_pkg::G_FOURTH: begin
                        b1 = n3; b2 = ratio_quot(os, n3, r3, r4); b3 = n3;
                    end
                    tccs_pkg::G_FIFTH: begin
                        b2 = ratio_quot(os, tu, r3, r4); k1 = n2 - n3; b3 = tu;
                    end
                    tccs_pkg::G_REV1: begin
                        k1 = n2 - n3; k2 = tu; b2 = wide_quot(os, tu, r3, r4, 1);
                    end
                    tccs_pkg::G_REV2: begin
                        k2 = tu; b1 = tu; b2 = wide_quot(os, tu, r3, r4, 1);
                    end
                    default: ;
                endcase
            end else begin
                lo = act < tgt ? act : tgt;
                hi = act < tgt ? tgt : act;
                if (lo == tccs_pkg::G_FIRST && hi == tccs_pkg::G_SECOND) begin
                    k1 = n2 - n3; k2 = minus_prod(tu, r3, os); b1 = n3; b3 = scaled(r3, os);
                end else if (lo == tccs_pkg::G_SECOND && hi == tccs_pkg::G_THIRD) begin
                    k2 = minus_prod(n3, r3, os); k3 = wide_quot(os, n3, r2, r3, 0);
                    b1 = n3; b3 = scaled(r3, os);
                end else if (lo == tccs_pkg::G_THIRD && hi == tccs_pkg::G_FOURTH) begin
                    vb2 = ratio_quot(os, n3, r3, r4);
                    k3 = clip(n3 - vb2); b1 = n3; b2 = vb2; b3 = n3;
                end else if (lo == tccs_pkg::G_FOURTH && hi == tccs_pkg::G_FIFTH) begin
                    k1 = n2 - n3; b1 = n3; b2 = ratio_quot(os, tu, r3, r4); b3 = tu;
                end
            end
        end
        f.k1 = 16'(clip(k1)); f.k2 = 16'(clip(k2)); f.k3 = 16'(clip(k3));
        f.b1 = 16'(clip(b1)); f.b2 = 16'(clip(b2)); f.b3 = 16'(clip(b3));
        return f;
    endfunction

    task automatic check_field(input string name, input logic signed [15:0] exp_v,
                               input logic signed [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    assign o_pending = slip_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        tccs_pkg::t_fields e;
        if (!i_rst_n) begin
            r2_q <= tccs_pkg::RATIO_SECOND_RST;
            r3_q <= tccs_pkg::RATIO_THIRD_RST;
            r4_q <= tccs_pkg::RATIO_FOURTH_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tccs_pkg::CFG_RATIO_SECOND: r2_q <= i_cfg_data;
                    tccs_pkg::CFG_RATIO_THIRD:  r3_q <= i_cfg_data;
                    tccs_pkg::CFG_RATIO_FOURTH: r4_q <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                slip_q.push_back(slip_speeds(i_n2, i_n3, i_tu, i_os, i_act, i_tgt, i_lmg,
                                             r2_q, r3_q, r4_q));
            if (i_valid) begin
                if (slip_q.size() == 0) begin
                    $error("unexpected result");
                    o_errors++;
                end else begin
                    e = slip_q.pop_front();
                    check_field("slip_k1", e.k1, i_slip.k1);
                    check_field("slip_k2", e.k2, i_slip.k2);
                    check_field("slip_k3", e.k3, i_slip.k3);
                    check_field("slip_b1", e.b1, i_slip.b1);
                    check_field("slip_b2", e.b2, i_slip.b2);
                    check_field("slip_b3", e.b3, i_slip.b3);
                end
            end
        end
    end

endmodule

// ===== test/transmission_clutch_slip_model_tb.sv =====
// Testbench top for the clutch slip model: drives requests and ratio writes.
// Checking is done by transmission_clutch_slip_model_chk. Depends on tccs_pkg.
`timescale 1ns / 1ps
module transmission_clutch_slip_model_tb;

    localparam int LATENCY = 21 + tccs_pkg::RATIO_FRAC_BITS;
    localparam int WD_LIMIT = 2000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic        [14:0] n2 = 0, n3 = 0, tu = 0, os = 0;
    logic        [3:0]  act = 0, tgt = 0, lmg = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic        [1:0]  cfg_index = tccs_pkg::CFG_RATIO_SECOND;
    logic        [15:0] cfg_data = 0;
    logic               o_valid;
    logic signed [15:0] slip_k1, slip_k2, slip_k3, slip_b1, slip_b2, slip_b3;
    tccs_pkg::t_fields  slip;
    int                 errors, pending;
    int                 idle_cycles = 0;
    bit                 no_gaps = 0;

    always #5 i_clk = ~i_clk;

    assign slip = {slip_k1, slip_k2, slip_k3, slip_b1, slip_b2, slip_b3};

    transmission_clutch_slip_model dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_n2_speed(n2), .i_n3_speed(n3), .i_turbine_speed(tu), .i_output_speed(os),
        .i_actual_gear(act), .i_target_gear(tgt), .i_last_motion_gear(lmg),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_valid(o_valid),
        .o_slip_k1(slip_k1), .o_slip_k2(slip_k2), .o_slip_k3(slip_k3),
        .o_slip_b1(slip_b1), .o_slip_b2(slip_b2), .o_slip_b3(slip_b3)
    );

    transmission_clutch_slip_model_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_n2(n2), .i_n3(n3), .i_tu(tu), .i_os(os), .i_act(act), .i_tgt(tgt), .i_lmg(lmg),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(o_valid), .i_slip(slip),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || o_valid || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_ratio(input logic [1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [14:0] a, input logic [14:0] b,
                                input logic [14:0] c, input logic [14:0] d,
                                input logic [3:0] ga, input logic [3:0] gt,
                                input logic [3:0] gl);
        if (!no_gaps && $urandom_range(0, 7) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        n2 <= a; n3 <= b; tu <= c; os <= d; act <= ga; tgt <= gt; lmg <= gl;
        start <= 1;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [14:0] rand_speed();
        logic [14:0] v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 15'h7fff;
            2: v = 15'($urandom_range(0, 300));
            default: v = 15'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [3:0] rand_gear();
        logic [3:0] v;
        v = $urandom_range(0, 3) == 0 ? 4'($urandom)
                                      : 4'($urandom_range(tccs_pkg::G_FIRST, tccs_pkg::G_REV2));
        return v;
    endfunction

    task automatic random_phase(input int count);
        logic [3:0] ga, gt;
        for (int i = 0; i < count; i++) begin
            ga = rand_gear();
            case ($urandom_range(0, 3))
                0: gt = ga;
                1: gt = (ga >= tccs_pkg::G_FIRST && ga < tccs_pkg::G_FIFTH) ? ga + 4'd1 : ga;
                2: gt = (ga > tccs_pkg::G_FIRST && ga <= tccs_pkg::G_FIFTH) ? ga - 4'd1 : ga;
                default: gt = rand_gear();
            endcase
            if ($urandom_range(0, 1)) begin
                ga = $urandom_range(0, 1) ? ga
                                          : 4'($urandom_range(tccs_pkg::G_NEUTRAL,
                                                              tccs_pkg::G_PARK));
                gt = $urandom_range(0, 1) ? gt
                                          : 4'($urandom_range(tccs_pkg::G_NEUTRAL,
                                                              tccs_pkg::G_PARK));
            end
            send_request(rand_speed(), rand_speed(), rand_speed(), rand_speed(),
                         ga, gt, 4'($urandom));
        end
        start <= 0;
    endtask

    logic [15:0] rset[6][3];

    initial begin
        rset[0] = '{16'h8000, 16'h7fff, 16'h0000};
        rset[1] = '{16'h7fff, 16'h8000, 16'h8000};
        rset[2] = '{16'd6103, 16'd6103, 16'd6103};
        rset[3] = '{16'h0001, 16'hffff, 16'h7fff};
        rset[4] = '{16'd14000, 16'd9000, 16'd5000};
        rset[5] = '{16'd9871, 16'd6103, 16'd4096};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int g = 0; g < 9; g++) begin
            send_request(15'd3000, 15'd1200, 15'd2500, 15'd800, 4'(g), 4'(g), 4'($urandom));
            send_request(15'h7fff, 15'd0, 15'h7fff, 15'h7fff, 4'(g), 4'(g), 4'(g));
        end
        send_request(15'd100, 15'd200, 15'd300, 15'd0, tccs_pkg::G_THIRD, tccs_pkg::G_THIRD,
                     tccs_pkg::G_FIRST);
        send_request(15'd1, 15'd2, 15'd3, 15'd4, tccs_pkg::G_NEUTRAL, tccs_pkg::G_FIFTH,
                     tccs_pkg::G_FIRST);
        send_request(15'd1, 15'd2, 15'd3, 15'd4, tccs_pkg::G_PARK, tccs_pkg::G_PARK,
                     tccs_pkg::G_REV1);
        send_request(15'd10, 15'd20, 15'd900, 15'd50, tccs_pkg::G_FIFTH, tccs_pkg::G_NEUTRAL,
                     tccs_pkg::G_REV2);
        send_request(15'd500, 15'h7fff, 15'd7, 15'h7fff, tccs_pkg::G_THIRD,
                     tccs_pkg::G_FOURTH, tccs_pkg::G_PARK);
        send_request(15'd500, 15'd400, 15'd7, 15'd900, tccs_pkg::G_FIRST, tccs_pkg::G_THIRD,
                     tccs_pkg::G_PARK);
        send_request(15'd0, 15'd0, 15'd0, 15'd9, 4'd15, 4'd15, 4'd15);
        start <= 0;
        drain();

        for (int s = 0; s < 6; s++) begin
            write_ratio(tccs_pkg::CFG_RATIO_SECOND, rset[s][0]);
            write_ratio(tccs_pkg::CFG_RATIO_THIRD, rset[s][1]);
            write_ratio(tccs_pkg::CFG_RATIO_FOURTH, rset[s][2]);
            if (s == 5) no_gaps = 1;
            random_phase(240);
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tccs_pkg.sv
hdl/transmission_clutch_slip_model.sv
test/transmission_clutch_slip_model_chk.sv
test/transmission_clutch_slip_model_tb.sv
